// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hw/rtl/gww_pkg.sv
// Types and constants of the greedy word wrap block.
package gww_pkg;

   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_SP  = 8'h20;
   localparam logic [7:0] CHAR_FF  = 8'h0C;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_HT  = 8'h09;
   localparam logic [7:0] CHAR_VT  = 8'h0B;

   localparam int FIELD_BITS = 16;
   localparam int RSP_DATA_BITS = 3 * FIELD_BITS;
   localparam logic [FIELD_BITS-1:0] WIDTH_RESET = 16'd80;
   localparam logic [FIELD_BITS-1:0] FIELD_MAX = 16'hFFFF;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW = 2;
   localparam int FIFO_CW = 3;

   typedef struct packed {
      logic                  final_line;
      logic [FIELD_BITS-1:0] line_number;
      logic [FIELD_BITS-1:0] line_length;
      logic [FIELD_BITS-1:0] line_offset;
   } line_type;

   function automatic logic is_separator(input logic [7:0] c);
      return (c == CHAR_SP) || (c == CHAR_FF) || (c == CHAR_LF) ||
             (c == CHAR_CR) || (c == CHAR_HT) || (c == CHAR_VT);
   endfunction

endpackage

// File: hw/rtl/greedy_word_wrap.sv
// Greedy word wrap line breaker with a result queue.
//
// Text bytes arrive on the req_ channel, one byte per request; byte zero ends
// the text and clears the text state for the next one. Finished lines leave on
// the rsp_ channel as offset, length and index in rsp_tdata, with rsp_tlast
// marking the last line of a text. The line width is written on the csr_
// channel, which is always ready; the user must write it only while the block
// is idle, which the block does not enforce. Each request is processed in the
// cycle it is accepted and its lines are registered into the result queue. One
// request is taken every cycle while the four-entry result queue has room for
// two lines; a request gives zero, one or two lines, so the sustained rate is
// one request per cycle unless the receiver takes fewer lines than produced.
// When the receiver stalls, lines collect in the queue and req_tready drops
// once fewer than two entries are free. Reset empties the queue, clears the
// text state and sets the line width to 80.
module greedy_word_wrap #(
   parameter int OFFSET_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // text_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // line_offset, line_length, line_number
   output logic        rsp_tlast,   // final_line
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // line_width
);

   localparam int WIDE = (OFFSET_BITS > gww_pkg::FIELD_BITS) ? OFFSET_BITS
                                                             : gww_pkg::FIELD_BITS;
   localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

   logic [15:0]              width_ff;
   logic [OFFSET_BITS-1:0]   pos_ff, pos_in;
   logic [OFFSET_BITS-1:0]   ols_ff, ols_in;
   logic [OFFSET_BITS-1:0]   ole_ff, ole_in;
   logic [OFFSET_BITS-1:0]   cws_ff, cws_in;
   logic                     inword_ff, inword_in;
   logic                     haswords_ff, haswords_in;
   logic [15:0]              lines_ff, lines_in;

   gww_pkg::line_type        fifo_ff [gww_pkg::FIFO_DEPTH];
   logic [gww_pkg::FIFO_AW-1:0] head_ff, tail_ff;
   logic [gww_pkg::FIFO_CW-1:0] count_ff, count_in;

   logic                     accept, pop, is_end, is_sep, close;
   logic [1:0]               n_push;
   logic [WIDE-1:0]          span, width_wide, wide_tmp0, wide_tmp1, wide_tmp2, wide_tmp3;
   logic [15:0]              lines_mid;
   gww_pkg::line_type        line_a, line_b, push0, push1;

   assign csr_ready  = 1'b1;
   assign req_tready = (count_ff <= gww_pkg::FIFO_CW'(gww_pkg::FIFO_DEPTH - 2));
   assign accept     = req_tvalid & req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign pop        = rsp_tvalid & rsp_tready;
   assign rsp_tdata  = {fifo_ff[head_ff].line_number, fifo_ff[head_ff].line_length,
                        fifo_ff[head_ff].line_offset};
   assign rsp_tlast  = fifo_ff[head_ff].final_line;

   always_comb begin
      is_end      = (req_tdata == gww_pkg::CHAR_NUL);
      is_sep      = gww_pkg::is_separator(req_tdata);
      pos_in      = pos_ff;
      ols_in      = ols_ff;
      ole_in      = ole_ff;
      cws_in      = cws_ff;
      inword_in   = inword_ff;
      haswords_in = haswords_ff;
      lines_mid   = lines_ff;
      close       = 1'b0;
      span        = WIDE'(pos_ff - ols_ff);
      width_wide  = WIDE'(width_ff);

      wide_tmp0 = WIDE'(ols_ff);
      wide_tmp1 = WIDE'(ole_ff - ols_ff);
      line_a.line_offset = wide_tmp0[15:0];
      line_a.line_length = wide_tmp1[15:0];
      line_a.line_number = lines_ff;
      line_a.final_line  = 1'b0;

      if (is_end || is_sep) begin
         if (inword_ff) begin
            close = haswords_ff && (span > width_wide);
            if (close || !haswords_ff) begin
               ols_in = cws_ff;
            end
            haswords_in = 1'b1;
            ole_in      = pos_ff;
            inword_in   = 1'b0;
            if (close) begin
               lines_mid = (lines_ff == gww_pkg::FIELD_MAX) ? lines_ff : lines_ff + 16'd1;
            end
         end
      end else if (!inword_ff) begin
         inword_in = 1'b1;
         cws_in    = pos_ff;
      end

      wide_tmp2 = WIDE'(ols_in);
      wide_tmp3 = WIDE'(ole_in - ols_in);
      line_b.line_offset = wide_tmp2[15:0];
      line_b.line_length = wide_tmp3[15:0];
      line_b.line_number = lines_mid;
      line_b.final_line  = 1'b1;
      lines_in = lines_mid;

      n_push = {1'b0, close};
      if (is_end) begin
         if (haswords_in) begin
            n_push = close ? 2'd2 : 2'd1;
         end
         pos_in      = '0;
         ols_in      = '0;
         ole_in      = '0;
         cws_in      = '0;
         inword_in   = 1'b0;
         haswords_in = 1'b0;
         lines_in    = '0;
      end else begin
         pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + OFFSET_BITS'(1);
      end

      push0 = close ? line_a : line_b;
      push1 = line_b;
      if (!accept) begin
         n_push = 2'd0;
      end
      count_in = count_ff + gww_pkg::FIFO_CW'(n_push) - gww_pkg::FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= gww_pkg::WIDTH_RESET;
         pos_ff      <= '0;
         ols_ff      <= '0;
         ole_ff      <= '0;
         cws_ff      <= '0;
         inword_ff   <= 1'b0;
         haswords_ff <= 1'b0;
         lines_ff    <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            width_ff <= csr_data;
         end
         if (accept) begin
            pos_ff      <= pos_in;
            ols_ff      <= ols_in;
            ole_ff      <= ole_in;
            cws_ff      <= cws_in;
            inword_ff   <= inword_in;
            haswords_ff <= haswords_in;
            lines_ff    <= lines_in;
         end
         if (pop) begin
            head_ff <= head_ff + gww_pkg::FIFO_AW'(1);
         end
         tail_ff  <= tail_ff + gww_pkg::FIFO_AW'(n_push);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         fifo_ff[tail_ff] <= push0;
      end
      if (n_push == 2'd2) begin
         fifo_ff[tail_ff + gww_pkg::FIFO_AW'(1)] <= push1;
      end
   end

endmodule

// File: hw/rtl/gww_checker.sv
// Port-level checks of the greedy word wrap block and their binding.
`include "assert_macros.svh"

module gww_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        csr_valid,
   input logic        csr_ready
);

   logic [gww_pkg::RSP_DATA_BITS:0] rsp_payload;
   assign rsp_payload = {rsp_tlast, rsp_tdata};

   `ASSERT_NEXT(rsp_valid_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `ASSERT_NEXT(rsp_payload_holds, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_payload))
   `ASSERT_NEXT(rsp_empty_after_reset, clock, 1'b0, reset, !rsp_tvalid)
   `ASSERT_IMPLY(stall_only_when_full, clock, reset, req_tvalid && !req_tready, rsp_tvalid)
   `ASSERT_IMPLY(csr_always_ready, clock, reset, csr_valid, csr_ready)

endmodule

bind greedy_word_wrap gww_checker u_gww_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);
